### hdl/shf_pkg.sv
// Shared types and constants of the slab histogram interface finder.
// Depends on nothing; all files but shf_ram use it by scoped names.
package shf_pkg;

	// Item operation codes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DENSITY   = 1'b1;

	localparam int DATA_W  = 24;   // Q8.16 lengths and densities
	localparam int COUNT_W = 16;   // histogram counts
	localparam int MDU_A_W = 48;   // multiply/divide unit wide operand
	localparam int MDU_B_W = 24;   // multiply/divide unit narrow operand

	// Operand selection of the shared multiply/divide unit
	typedef enum logic [2:0] {
		MDU_BIN,
		MDU_T1,
		MDU_T2,
		MDU_T3,
		MDU_TDIV,
		MDU_LZ,
		MDU_RZ
	} mdu_sel_t;

	// Read address selection of the smoothed count memory
	typedef enum logic [1:0] {
		SA_CM1,
		SA_C,
		SA_CP1,
		SA_POS
	} s_addr_t;

	typedef struct packed {
		logic      start_frame;
		logic      mdu_start;
		mdu_sel_t  mdu_sel;
		logic      cap_bin;
		logic      bin_dflt;
		logic      hist_inc;
		logic      cap_t;
		logic      sm_init;
		logic      sm_step;
		logic      sm_last;
		logic      sr_init;
		s_addr_t   s_addr;
		logic      sum_load;
		logic      sum_acc;
		logic      sr_next;
		logic      walk_init;
		logic      left_step;
		logic      right_step;
		logic      left_cap;
		logic      right_cap;
		logic      res_clr;
		logic      cap_lz;
		logic      cap_rz;
	} cmd_t;

	typedef struct packed {
		logic mdu_done;
		logic bz_zero;
		logic sweep_end;
		logic sum_le_t;
		logic p_last;
		logic s_ge_t;
		logic k_last;
	} stat_t;

endpackage

### hdl/shf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module shf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/shf_mdu.sv
// Bit-serial multiply/divide unit: 24-step shift-add multiply (result >> 16)
// and 48-step restoring divide. Depends on shf_pkg.
module shf_mdu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        is_div,
	input  logic [shf_pkg::MDU_A_W-1:0] a,
	input  logic [shf_pkg::MDU_B_W-1:0] b,
	output logic [shf_pkg::MDU_A_W-1:0] res,
	output logic                        done
);

	localparam int AW   = shf_pkg::MDU_A_W;
	localparam int BW   = shf_pkg::MDU_B_W;
	localparam int PW   = AW + BW;
	localparam int CNTW = $clog2(AW);

	logic            busy_q;
	logic            done_q;
	logic            div_q;
	logic [CNTW-1:0] cnt_q;
	logic [AW-1:0]   x_q;     // multiplicand, or dividend shifting into quotient
	logic [BW-1:0]   opb_q;   // multiplier shifting out, or divisor
	logic [BW-1:0]   rem_q;
	logic [PW-1:0]   acc_q;

	logic [BW:0]     rem_sh;
	logic            ge;
	logic [BW-1:0]   rem_nx;
	logic [PW-1:0]   acc_nx;

	always_comb begin
		rem_sh = {rem_q, x_q[AW-1]};
		ge     = rem_sh >= {1'b0, opb_q};
		rem_nx = ge ? BW'(rem_sh - {1'b0, opb_q}) : rem_sh[BW-1:0];
		acc_nx = {acc_q[PW-2:0], 1'b0} + (opb_q[BW-1] ? PW'(x_q) : PW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= is_div ? CNTW'(AW - 1) : CNTW'(BW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			x_q   <= a;
			opb_q <= b;
			rem_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				x_q   <= {x_q[AW-2:0], ge};
				rem_q <= rem_nx;
			end else begin
				acc_q <= acc_nx;
				opb_q <= {opb_q[BW-2:0], 1'b0};
			end
		end
	end

	assign res  = div_q ? x_q : acc_q[AW+15:16];
	assign done = done_q;

endmodule

### hdl/shf_dp.sv
// Datapath: configuration and box registers, histogram and smoothed memories,
// sweep, search and walk registers, result registers. Depends on shf_pkg,
// shf_ram and shf_mdu.
module shf_dp #(
	parameter int MAX_BINS = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [shf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [shf_pkg::DATA_W-1:0]          cfg_data,
	input  logic [shf_pkg::DATA_W-1:0]          z_pos,
	input  logic [shf_pkg::DATA_W-1:0]          box_x,
	input  logic [shf_pkg::DATA_W-1:0]          box_y,
	input  logic [shf_pkg::DATA_W-1:0]          box_z,
	input  shf_pkg::cmd_t                       cmd,
	output shf_pkg::stat_t                      stat,
	output logic                                found,
	output logic [7:0]                          left_bin,
	output logic [6:0]                          right_bin,
	output logic [shf_pkg::DATA_W-1:0]          left_z,
	output logic [shf_pkg::DATA_W-1:0]          right_z
);

	localparam int IW = $clog2(MAX_BINS);
	localparam int NW = $clog2(MAX_BINS + 1);
	localparam int DW = shf_pkg::DATA_W;
	localparam int CW = shf_pkg::COUNT_W;
	localparam int AW = shf_pkg::MDU_A_W;
	localparam int BW = shf_pkg::MDU_B_W;

	function automatic logic [IW-1:0] wdec(input logic [IW-1:0] x, input logic [IW-1:0] last);
		return (x == '0) ? last : x - 1'b1;
	endfunction

	function automatic logic [IW-1:0] winc(input logic [IW-1:0] x, input logic [IW-1:0] last);
		return (x == last) ? '0 : x + 1'b1;
	endfunction

	// floor(x/3) for x below 3*2^16 by reciprocal multiply
	function automatic logic [CW-1:0] div3(input logic [CW+1:0] x);
		logic [CW+21:0] p;
		p = (CW+22)'(x) * (CW+22)'(20'd349526);
		return p[CW+19:20];
	endfunction

	// configuration and frame registers
	logic [7:0]          bin_count_q;
	logic [DW-1:0]       dens_q;
	logic [DW-1:0]       box_x_q, box_y_q, box_z_q;
	logic [MAX_BINS-1:0] valid_q;

	logic [31:0]   n_w;
	logic [NW-1:0] n;
	logic [NW-1:0] nm1_w;
	logic [NW-1:0] half_w;
	logic [IW-1:0] last;
	logic [IW-1:0] mid;

	always_comb begin
		n_w = 32'(bin_count_q);
		if (n_w < 32'd3) begin
			n_w = 32'd3;
		end else if (n_w > 32'(MAX_BINS)) begin
			n_w = 32'(MAX_BINS);
		end
		n      = n_w[NW-1:0];
		nm1_w  = n - 1'b1;
		half_w = n >> 1;
		last   = nm1_w[IW-1:0];
		mid    = half_w[IW-1:0];
	end

	// working registers
	logic [IW-1:0]  bin_q;
	logic [AW-1:0]  t_q;
	logic [NW-1:0]  rd_idx_q;
	logic           arr_vld_s1;
	logic [IW-1:0]  arr_idx_s1;
	logic           hv_s1;
	logic [CW-1:0]  win_a_q, win_b_q;
	logic [IW-1:0]  c_q, up_q, dn_q, p_q, pos_q, k_q;
	logic [CW+1:0]  sum_q;
	logic [IW-1:0]  left_q, right_q;
	logic           found_q;
	logic [7:0]     left_bin_q;
	logic [6:0]     right_bin_q;
	logic [DW-1:0]  left_z_q, right_z_q;

	// memories
	logic [IW-1:0] h_raddr;
	logic [CW-1:0] h_rdata;
	logic [CW-1:0] h_val;
	logic [CW-1:0] h_inc;
	logic          s_we;
	logic [IW-1:0] s_waddr, s_raddr;
	logic [CW-1:0] s_wdata, s_rdata;

	assign h_raddr = cmd.sm_step ? rd_idx_q[IW-1:0] : bin_q;
	assign h_val   = hv_s1 ? h_rdata : '0;
	assign h_inc   = (h_val == {CW{1'b1}}) ? h_val : h_val + 1'b1;

	shf_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_hist (
		.clk   (clk),
		.we    (cmd.hist_inc),
		.waddr (bin_q),
		.wdata (h_inc),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	always_comb begin
		s_we    = cmd.sm_last || (arr_vld_s1 && (arr_idx_s1 != '0));
		s_waddr = cmd.sm_last ? last : arr_idx_s1 - 1'b1;
		if (cmd.sm_last) begin
			s_wdata = CW'(((CW+1)'(win_a_q) + (CW+1)'(win_b_q)) >> 1);
		end else if (arr_idx_s1 == IW'(1)) begin
			s_wdata = CW'(((CW+1)'(win_b_q) + (CW+1)'(h_val)) >> 1);
		end else begin
			s_wdata = div3((CW+2)'(win_a_q) + (CW+2)'(win_b_q) + (CW+2)'(h_val));
		end
		case (cmd.s_addr)
			shf_pkg::SA_CM1: s_raddr = wdec(c_q, last);
			shf_pkg::SA_C:   s_raddr = c_q;
			shf_pkg::SA_CP1: s_raddr = winc(c_q, last);
			shf_pkg::SA_POS: s_raddr = pos_q;
			default:         s_raddr = c_q;
		endcase
	end

	shf_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_smooth (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// multiply/divide unit and its operands
	logic [DW+NW-1:0] bin_prod, lz_prod, rz_prod;
	logic [NW-1:0]    lb;
	logic [AW-1:0]    mdu_a, mdu_res;
	logic [BW-1:0]    mdu_b;
	logic             mdu_div, mdu_done;

	assign lb       = NW'({1'b0, left_q}) + NW'(1);
	assign bin_prod = (DW+NW)'(z_pos) * (DW+NW)'(n);
	assign lz_prod  = (DW+NW)'(box_z_q) * (DW+NW)'(lb);
	assign rz_prod  = (DW+NW)'(box_z_q) * (DW+NW)'(right_q);

	always_comb begin
		case (cmd.mdu_sel)
			shf_pkg::MDU_BIN: begin
				mdu_a = AW'(bin_prod); mdu_b = box_z_q; mdu_div = 1'b1;
			end
			shf_pkg::MDU_T1: begin
				mdu_a = AW'(dens_q); mdu_b = box_x_q; mdu_div = 1'b0;
			end
			shf_pkg::MDU_T2: begin
				mdu_a = mdu_res; mdu_b = box_y_q; mdu_div = 1'b0;
			end
			shf_pkg::MDU_T3: begin
				mdu_a = mdu_res; mdu_b = box_z_q; mdu_div = 1'b0;
			end
			shf_pkg::MDU_TDIV: begin
				mdu_a = mdu_res; mdu_b = BW'(n); mdu_div = 1'b1;
			end
			shf_pkg::MDU_LZ: begin
				mdu_a = AW'(lz_prod); mdu_b = BW'(n); mdu_div = 1'b1;
			end
			shf_pkg::MDU_RZ: begin
				mdu_a = AW'(rz_prod); mdu_b = BW'(n); mdu_div = 1'b1;
			end
			default: begin
				mdu_a = '0; mdu_b = '0; mdu_div = 1'b0;
			end
		endcase
	end

	shf_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mdu_start),
		.is_div (mdu_div),
		.a      (mdu_a),
		.b      (mdu_b),
		.res    (mdu_res),
		.done   (mdu_done)
	);

	// compares
	logic [CW+1:0] sum_tot;
	logic [AW-1:0] sum_sh, s_sh;
	logic [IW-1:0] p_nx;
	logic [IW-1:0] up_nx, dn_nx;

	always_comb begin
		sum_tot = sum_q + (CW+2)'(s_rdata);
		sum_sh  = AW'({sum_tot, 16'h0000});
		s_sh    = AW'({s_rdata, 16'h0000});
		p_nx    = p_q + 1'b1;
		up_nx   = winc(up_q, last);
		dn_nx   = wdec(dn_q, last);
	end

	assign stat.mdu_done  = mdu_done;
	assign stat.bz_zero   = (box_z_q == '0);
	assign stat.sweep_end = arr_vld_s1 && (arr_idx_s1 == last);
	assign stat.sum_le_t  = sum_sh <= t_q;
	assign stat.p_last    = (p_q == last);
	assign stat.s_ge_t    = s_sh >= t_q;
	assign stat.k_last    = (k_q == last);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= 8'd100;
			dens_q      <= '0;
			box_x_q     <= DW'(24'h010000);
			box_y_q     <= DW'(24'h010000);
			box_z_q     <= DW'(24'h010000);
			valid_q     <= '0;
			arr_vld_s1  <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == shf_pkg::REG_BIN_COUNT)) begin
				bin_count_q <= cfg_data[7:0];
			end
			if (cfg_we && (cfg_index == shf_pkg::REG_DENSITY)) begin
				dens_q <= cfg_data;
			end
			if (cmd.start_frame) begin
				box_x_q <= box_x;
				box_y_q <= box_y;
				box_z_q <= box_z;
				valid_q <= '0;
			end else if (cmd.hist_inc) begin
				valid_q[bin_q] <= 1'b1;
			end
			arr_vld_s1 <= cmd.sm_step && (rd_idx_q < n);
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		hv_s1 <= valid_q[h_raddr];
		if (cmd.cap_bin) begin
			bin_q <= (mdu_res > AW'(nm1_w)) ? last : mdu_res[IW-1:0];
		end else if (cmd.bin_dflt) begin
			bin_q <= last;
		end
		if (cmd.cap_t) begin
			t_q <= mdu_res;
		end
		if (cmd.sm_init) begin
			rd_idx_q <= '0;
		end else if (cmd.sm_step && (rd_idx_q < n)) begin
			rd_idx_q   <= rd_idx_q + 1'b1;
			arr_idx_s1 <= rd_idx_q[IW-1:0];
		end
		if (arr_vld_s1) begin
			win_a_q <= win_b_q;
			win_b_q <= h_val;
		end
		if (cmd.sr_init) begin
			c_q  <= mid;
			up_q <= mid;
			dn_q <= mid;
			p_q  <= '0;
		end else if (cmd.sr_next) begin
			p_q <= p_nx;
			if (p_nx[0]) begin
				up_q <= up_nx;
				c_q  <= up_nx;
			end else begin
				dn_q <= dn_nx;
				c_q  <= dn_nx;
			end
		end
		if (cmd.sum_load) begin
			sum_q <= (CW+2)'(s_rdata);
		end else if (cmd.sum_acc) begin
			sum_q <= sum_tot;
		end
		if (cmd.walk_init) begin
			pos_q <= c_q;
			k_q   <= '0;
		end else if (cmd.left_step) begin
			pos_q <= wdec(pos_q, last);
			k_q   <= k_q + 1'b1;
		end else if (cmd.right_step) begin
			pos_q <= winc(pos_q, last);
			k_q   <= k_q + 1'b1;
		end
		if (cmd.left_cap) begin
			left_q <= pos_q;
		end
		if (cmd.res_clr) begin
			found_q     <= 1'b0;
			left_bin_q  <= '0;
			right_bin_q <= '0;
			left_z_q    <= '0;
			right_z_q   <= '0;
		end else begin
			if (cmd.right_cap) begin
				right_q     <= pos_q;
				found_q     <= 1'b1;
				left_bin_q  <= 8'(32'(lb));
				right_bin_q <= 7'(32'(pos_q));
			end
			if (cmd.cap_lz) begin
				left_z_q <= mdu_res[DW-1:0];
			end
			if (cmd.cap_rz) begin
				right_z_q <= mdu_res[DW-1:0];
			end
		end
	end

	assign found     = found_q;
	assign left_bin  = left_bin_q;
	assign right_bin = right_bin_q;
	assign left_z    = left_z_q;
	assign right_z   = right_z_q;

endmodule

### hdl/shf_ctrl.sv
// Controller state machine: sequences start, sample and end items over the
// datapath through command and status structs. Depends on shf_pkg.
module shf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     op,
	output logic           busy,
	output logic           done,
	output shf_pkg::cmd_t  cmd,
	input  shf_pkg::stat_t stat
);

	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001,
		ST_SDIV   = 20'h00002,
		ST_SRD    = 20'h00004,
		ST_SWR    = 20'h00008,
		ST_M1     = 20'h00010,
		ST_M2     = 20'h00020,
		ST_M3     = 20'h00040,
		ST_TDIV   = 20'h00080,
		ST_SMRD   = 20'h00100,
		ST_SMLAST = 20'h00200,
		ST_SRA    = 20'h00400,
		ST_SRB    = 20'h00800,
		ST_SRC    = 20'h01000,
		ST_SRE    = 20'h02000,
		ST_LWA    = 20'h04000,
		ST_LWB    = 20'h08000,
		ST_RWA    = 20'h10000,
		ST_RWB    = 20'h20000,
		ST_LZ     = 20'h40000,
		ST_RZ     = 20'h80000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						shf_pkg::OP_START: cmd.start_frame = 1'b1;
						shf_pkg::OP_SAMPLE: begin
							if (stat.bz_zero) begin
								cmd.bin_dflt = 1'b1;
								state_d      = ST_SRD;
							end else begin
								cmd.mdu_start = 1'b1;
								cmd.mdu_sel   = shf_pkg::MDU_BIN;
								state_d       = ST_SDIV;
							end
						end
						shf_pkg::OP_END: begin
							cmd.res_clr   = 1'b1;
							cmd.mdu_start = 1'b1;
							cmd.mdu_sel   = shf_pkg::MDU_T1;
							state_d       = ST_M1;
						end
						default: ;
					endcase
				end
			end
			ST_SDIV: begin
				if (stat.mdu_done) begin
					cmd.cap_bin = 1'b1;
					state_d     = ST_SRD;
				end
			end
			ST_SRD: state_d = ST_SWR;
			ST_SWR: begin
				cmd.hist_inc = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_M1: begin
				if (stat.mdu_done) begin
					cmd.mdu_start = 1'b1;
					cmd.mdu_sel   = shf_pkg::MDU_T2;
					state_d       = ST_M2;
				end
			end
			ST_M2: begin
				if (stat.mdu_done) begin
					cmd.mdu_start = 1'b1;
					cmd.mdu_sel   = shf_pkg::MDU_T3;
					state_d       = ST_M3;
				end
			end
			ST_M3: begin
				if (stat.mdu_done) begin
					cmd.mdu_start = 1'b1;
					cmd.mdu_sel   = shf_pkg::MDU_TDIV;
					state_d       = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (stat.mdu_done) begin
					cmd.cap_t   = 1'b1;
					cmd.sm_init = 1'b1;
					state_d     = ST_SMRD;
				end
			end
			ST_SMRD: begin
				cmd.sm_step = 1'b1;
				if (stat.sweep_end) begin
					state_d = ST_SMLAST;
				end
			end
			ST_SMLAST: begin
				cmd.sm_last = 1'b1;
				cmd.sr_init = 1'b1;
				state_d     = ST_SRA;
			end
			ST_SRA: begin
				cmd.s_addr = shf_pkg::SA_CM1;
				state_d    = ST_SRB;
			end
			ST_SRB: begin
				cmd.s_addr   = shf_pkg::SA_C;
				cmd.sum_load = 1'b1;
				state_d      = ST_SRC;
			end
			ST_SRC: begin
				cmd.s_addr  = shf_pkg::SA_CP1;
				cmd.sum_acc = 1'b1;
				state_d     = ST_SRE;
			end
			ST_SRE: begin
				if (stat.sum_le_t) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_LWA;
				end else if (stat.p_last) begin
					cmd.res_clr = 1'b1;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.sr_next = 1'b1;
					state_d     = ST_SRA;
				end
			end
			ST_LWA: begin
				cmd.s_addr = shf_pkg::SA_POS;
				state_d    = ST_LWB;
			end
			ST_LWB: begin
				cmd.s_addr = shf_pkg::SA_POS;
				if (stat.s_ge_t) begin
					cmd.left_cap  = 1'b1;
					cmd.walk_init = 1'b1;
					state_d       = ST_RWA;
				end else if (stat.k_last) begin
					cmd.res_clr = 1'b1;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.left_step = 1'b1;
					state_d       = ST_LWA;
				end
			end
			ST_RWA: begin
				cmd.s_addr = shf_pkg::SA_POS;
				state_d    = ST_RWB;
			end
			ST_RWB: begin
				cmd.s_addr = shf_pkg::SA_POS;
				if (stat.s_ge_t) begin
					cmd.right_cap = 1'b1;
					state_d       = ST_LZ;
				end else if (stat.k_last) begin
					cmd.res_clr = 1'b1;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.right_step = 1'b1;
					state_d        = ST_RWA;
				end
			end
			ST_LZ: begin
				cmd.mdu_sel = shf_pkg::MDU_LZ;
				if (!stat.mdu_done) begin
					cmd.mdu_start = 1'b0;
				end
				if (stat.mdu_done) begin
					cmd.cap_lz    = 1'b1;
					cmd.mdu_start = 1'b1;
					cmd.mdu_sel   = shf_pkg::MDU_RZ;
					state_d       = ST_RZ;
				end
			end
			ST_RZ: begin
				if (stat.mdu_done) begin
					cmd.cap_rz = 1'b1;
					done_d     = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// kick the left position divide on the cycle the right edge is found
		if (state_q == ST_RWB && stat.s_ge_t) begin
			cmd.mdu_start = 1'b1;
			cmd.mdu_sel   = shf_pkg::MDU_LZ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == shf_pkg::OP_END) |=> busy)
		else $error("end item did not start computation");
	a_mdu_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mdu_done |-> (state_q == ST_SDIV || state_q == ST_M1 || state_q == ST_M2 ||
			state_q == ST_M3 || state_q == ST_TDIV || state_q == ST_LZ || state_q == ST_RZ))
		else $error("multiply/divide completion outside a wait state");

endmodule

### hdl/slab_histogram_interface_finder.sv
// Slab histogram interface finder, top level. A sample item bins z with the
// 48-step serial divider, which it skips when the box has no z length. An end
// item is paced by the serial multiply/divide unit and one smoothed-memory read
// per step. One item at a time; busy is high until a sample or end item is done;
// the receiver cannot stall. Reset (arst_n, async) sets 100 bins, zero density,
// unit box and an empty histogram.
module slab_histogram_interface_finder #(
	parameter int MAX_BINS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [shf_pkg::DATA_W-1:0]    z_pos,
	input  logic [shf_pkg::DATA_W-1:0]    box_x,
	input  logic [shf_pkg::DATA_W-1:0]    box_y,
	input  logic [shf_pkg::DATA_W-1:0]    box_z,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [shf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [shf_pkg::DATA_W-1:0]    cfg_data,
	// result channel, one-cycle strobe
	output logic                          done,
	output logic                          found,
	output logic [7:0]                    left_bin,
	output logic [6:0]                    right_bin,
	output logic [shf_pkg::DATA_W-1:0]    left_z,
	output logic [shf_pkg::DATA_W-1:0]    right_z
);

	shf_pkg::cmd_t  cmd;
	shf_pkg::stat_t stat;

	// Controller: one-hot sequencer for start, sample and end items.
	// A sample bins z with one divide, then reads, increments and writes back.
	// An end item builds the threshold (three multiplies, one divide),
	// sweeps the histogram into the smoothed memory, spirals out from the
	// middle bin, walks both edges and divides out the two positions.
	shf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Datapath: registers, the two bin memories, the shared serial
	// multiply/divide unit and the result registers that hold each end item's
	// result for its strobe cycle.
	shf_dp #(.MAX_BINS(MAX_BINS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.z_pos     (z_pos),
		.box_x     (box_x),
		.box_y     (box_y),
		.box_z     (box_z),
		.cmd       (cmd),
		.stat      (stat),
		.found     (found),
		.left_bin  (left_bin),
		.right_bin (right_bin),
		.left_z    (left_z),
		.right_z   (right_z)
	);

endmodule
